### rtl/core/word_rle_encoder_unit_assert.svh
// Assertion macros shared by the word run-length encoder modules.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef WORD_RLE_ENCODER_UNIT_ASSERT_SVH
`define WORD_RLE_ENCODER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WRE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WRE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/wre_pkg.sv
// Package for the word run-length encoder: sizes, command format and helpers.
// Used by the front, the command queue, the back and the top level.
`timescale 1ns / 1ps

package wre_pkg;

  localparam int WORD_W    = 32;
  localparam int REP_W     = 31;
  localparam int LIT_MAX   = 32;
  localparam int LIT_CW    = $clog2(LIT_MAX + 1);
  localparam int LIT_IW    = $clog2(LIT_MAX);
  localparam int CMD_DEPTH = 4;
  localparam int CMD_PW    = $clog2(CMD_DEPTH);

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_PAIR,
    OP_LITS
  } op_t;

  // OP_WRITE: store val at literal index cnt.
  // OP_PAIR:  send hdr, then val.
  // OP_LITS:  send hdr, then cnt stored literals, then val when tail is set.
  typedef struct packed {
    op_t               op;
    logic [WORD_W-1:0] hdr;
    logic [WORD_W-1:0] val;
    logic [LIT_CW-1:0] cnt;
    logic              tail;
    logic              last_out;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_VAL,
    BK_LIT
  } bk_state_t;

  function automatic logic [WORD_W-1:0] swap32(input logic [WORD_W-1:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

### rtl/core/wre_front.sv
// Front end of the word run-length encoder: run tracking and command generation.
// Depends on wre_pkg; feeds commands to the queue one per cycle while it has room.
`timescale 1ns / 1ps

`include "word_rle_encoder_unit_assert.svh"

module wre_front
  import wre_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [WORD_W-1:0] s_tdata,   // data_word
  input  logic              s_tlast,   // last_word
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output cmd_t              cmd
);

  logic              have_prev, have_prev_next;
  logic              is_lit, is_lit_next;
  logic [REP_W-1:0]  rep_cnt, rep_cnt_next;
  logic [LIT_CW-1:0] lit_cnt, lit_cnt_next;
  logic [WORD_W-1:0] prev_word, prev_word_next;

  cmd_t              pend [3];
  logic [1:0]        pend_n;
  cmd_t              list_next [3];
  logic [1:0]        list_n;

  logic accept;
  logic do_push;

  function automatic cmd_t mk_cmd(input op_t op, input logic [WORD_W-1:0] hdr,
                                  input logic [WORD_W-1:0] val,
                                  input logic [LIT_CW-1:0] cnt, input logic tail);
    cmd_t c;
    c.op       = op;
    c.hdr      = hdr;
    c.val      = val;
    c.cnt      = cnt;
    c.tail     = tail;
    c.last_out = 1'b0;
    return c;
  endfunction

  assign cmd_valid = (pend_n != 2'd0);
  assign cmd       = pend[0];
  assign do_push   = cmd_valid && cmd_ready;
  assign s_tready  = (pend_n == 2'd0) || (pend_n == 2'd1 && cmd_ready);
  assign accept    = s_tvalid && s_tready;

  always_comb begin : classify
    logic              eq;
    logic [1:0]        n;
    logic [LIT_IW-1:0] widx;
    logic [1:0]        fi;
    logic              found;
    cmd_t              lst [3];

    eq   = (s_tdata == prev_word);
    n    = 2'd0;
    widx = '0;
    fi   = 2'd0;
    found = 1'b0;
    for (int i = 0; i < 3; i++) begin
      lst[i] = mk_cmd(OP_WRITE, '0, '0, '0, 1'b0);
    end

    have_prev_next = have_prev;
    is_lit_next    = is_lit;
    rep_cnt_next   = rep_cnt;
    lit_cnt_next   = lit_cnt;
    prev_word_next = prev_word;

    if (!have_prev) begin
      prev_word_next = s_tdata;
      is_lit_next    = 1'b0;
      rep_cnt_next   = '0;
      have_prev_next = 1'b1;
    end else if (!is_lit && rep_cnt == '0) begin
      if (eq) begin
        rep_cnt_next = REP_W'(1);
      end else begin
        lst[n] = mk_cmd(OP_WRITE, '0, prev_word, '0, 1'b0);
        n = n + 2'd1;
        prev_word_next = s_tdata;
        is_lit_next    = 1'b1;
        lit_cnt_next   = LIT_CW'(1);
      end
    end else if (!is_lit) begin
      if (eq && rep_cnt != '1) begin
        rep_cnt_next = rep_cnt + REP_W'(1);
      end else begin
        // A full repeat run goes out before one more copy could overflow it.
        lst[n] = mk_cmd(OP_PAIR, {1'b0, rep_cnt}, prev_word, '0, 1'b0);
        n = n + 2'd1;
        rep_cnt_next   = '0;
        prev_word_next = s_tdata;
      end
    end else begin
      if (eq) begin
        lst[n] = mk_cmd(OP_LITS, 32'd0 - (32'(lit_cnt) - 32'd1), '0, lit_cnt, 1'b0);
        n = n + 2'd1;
        is_lit_next  = 1'b0;
        rep_cnt_next = REP_W'(1);
      end else begin
        if (lit_cnt == LIT_CW'(LIT_MAX)) begin
          lst[n] = mk_cmd(OP_LITS, 32'd0 - 32'(LIT_MAX - 1), '0,
                          LIT_CW'(LIT_MAX), 1'b0);
          n = n + 2'd1;
          widx = '0;
          lit_cnt_next = LIT_CW'(1);
        end else begin
          widx = lit_cnt[LIT_IW-1:0];
          lit_cnt_next = lit_cnt + LIT_CW'(1);
        end
        lst[n] = mk_cmd(OP_WRITE, '0, prev_word, LIT_CW'(widx), 1'b0);
        n = n + 2'd1;
        prev_word_next = s_tdata;
      end
    end

    if (s_tlast) begin
      if (!is_lit_next) begin
        lst[n] = mk_cmd(OP_PAIR, {1'b0, rep_cnt_next}, prev_word_next, '0, 1'b0);
        n = n + 2'd1;
      end else if (lit_cnt_next == LIT_CW'(LIT_MAX)) begin
        // The buffer is full, so the pending word follows as a run of one.
        lst[n] = mk_cmd(OP_LITS, 32'd0 - 32'(LIT_MAX - 1), '0,
                        LIT_CW'(LIT_MAX), 1'b0);
        n = n + 2'd1;
        lst[n] = mk_cmd(OP_PAIR, '0, prev_word_next, '0, 1'b0);
        n = n + 2'd1;
      end else begin
        lst[n] = mk_cmd(OP_LITS, 32'd0 - 32'(lit_cnt_next), prev_word_next,
                        lit_cnt_next, 1'b1);
        n = n + 2'd1;
      end
      have_prev_next = 1'b0;
      is_lit_next    = 1'b0;
      rep_cnt_next   = '0;
    end

    // The last command that sends words carries the end-of-item mark.
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < n && lst[i].op != OP_WRITE) begin
        fi    = 2'(i);
        found = 1'b1;
      end
    end
    if (found) begin
      lst[fi].last_out = 1'b1;
    end

    list_next = lst;
    list_n    = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev <= 1'b0;
      is_lit    <= 1'b0;
      rep_cnt   <= '0;
      lit_cnt   <= '0;
      prev_word <= '0;
      pend_n    <= 2'd0;
    end else begin
      if (accept) begin
        have_prev <= have_prev_next;
        is_lit    <= is_lit_next;
        rep_cnt   <= rep_cnt_next;
        lit_cnt   <= lit_cnt_next;
        prev_word <= prev_word_next;
        pend_n    <= list_n;
      end else if (do_push) begin
        pend_n <= pend_n - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend <= list_next;
    end else if (do_push) begin
      pend[0] <= pend[1];
      pend[1] <= pend[2];
    end
  end

  `WRE_ASSERT_NEXT(a_last_ends_stream, accept && s_tlast && !rst, !have_prev, "last item did not end the stream")
  `WRE_ASSERT_NOW(a_lit_count_range, is_lit, lit_cnt != '0 && lit_cnt <= LIT_CW'(LIT_MAX), "literal count out of range")

endmodule

### rtl/core/wre_cmd_fifo.sv
// Short command queue between the front and the back of the encoder.
// Depends on wre_pkg for the command type and queue depth.
`timescale 1ns / 1ps

`include "word_rle_encoder_unit_assert.svh"

module wre_cmd_fifo
  import wre_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  cmd_t              q [CMD_DEPTH];
  logic [CMD_PW-1:0] wp;
  logic [CMD_PW-1:0] rp;
  logic [CMD_PW:0]   cnt;
  logic              push;
  logic              pop;

  assign push_ready = (cnt != (CMD_PW + 1)'(CMD_DEPTH));
  assign pop_valid  = (cnt != '0);
  assign pop_cmd    = q[rp];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= (wp == CMD_PW'(CMD_DEPTH - 1)) ? '0 : wp + CMD_PW'(1);
      end
      if (pop) begin
        rp <= (rp == CMD_PW'(CMD_DEPTH - 1)) ? '0 : rp + CMD_PW'(1);
      end
      if (push && !pop) begin
        cnt <= cnt + (CMD_PW + 1)'(1);
      end else if (pop && !push) begin
        cnt <= cnt - (CMD_PW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= push_cmd;
    end
  end

  `WRE_ASSERT_NOW(a_cnt_bound, 1'b1, cnt <= (CMD_PW + 1)'(CMD_DEPTH), "queue count above depth")
  `WRE_ASSERT_NEXT(a_cnt_grows, push && !pop && !rst, cnt == $past(cnt) + (CMD_PW + 1)'(1), "queue count did not grow on push")

endmodule

### rtl/core/wre_back.sv
// Back end of the word run-length encoder: executes commands, owns the literal
// buffer and the output register. Depends on wre_pkg.
`timescale 1ns / 1ps

`include "word_rle_encoder_unit_assert.svh"

module wre_back
  import wre_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              swap_header,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  cmd_t              cmd,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [WORD_W-1:0] m_tdata,   // code_word
  output logic              m_tuser,   // is_header
  output logic              m_tlast    // final_of_item
);

  bk_state_t         state, state_next;
  logic [LIT_IW-1:0] k, k_next;
  logic [WORD_W-1:0] lit_mem [LIT_MAX];
  logic [WORD_W-1:0] rd_data;
  logic [LIT_IW-1:0] rd_addr;
  logic              rd_en;
  logic              mem_we;
  logic              out_free;
  logic              load;
  logic [WORD_W-1:0] ld_word;
  logic              ld_hdr;
  logic              ld_last;
  logic              k_end;

  assign out_free = !m_tvalid || m_tready;
  assign k_end    = ((LIT_CW'(k) + LIT_CW'(1)) == cmd.cnt);

  always_comb begin
    state_next = state;
    k_next     = k;
    cmd_ready  = 1'b0;
    mem_we     = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = k;
    load       = 1'b0;
    ld_word    = cmd.val;
    ld_hdr     = 1'b0;
    ld_last    = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (cmd_valid) begin
          if (cmd.op == OP_WRITE) begin
            mem_we    = 1'b1;
            cmd_ready = 1'b1;
          end else if (out_free) begin
            load    = 1'b1;
            ld_word = swap_header ? swap32(cmd.hdr) : cmd.hdr;
            ld_hdr  = 1'b1;
            if (cmd.op == OP_PAIR) begin
              state_next = BK_VAL;
            end else begin
              rd_en      = 1'b1;
              rd_addr    = '0;
              k_next     = '0;
              state_next = BK_LIT;
            end
          end
        end
      end
      BK_VAL: begin
        if (out_free) begin
          load       = 1'b1;
          ld_word    = cmd.val;
          ld_last    = cmd.last_out;
          cmd_ready  = 1'b1;
          state_next = BK_IDLE;
        end
      end
      BK_LIT: begin
        // rd_data already holds literal k; the next one is read as this one leaves.
        if (out_free) begin
          load    = 1'b1;
          ld_word = rd_data;
          ld_last = k_end && !cmd.tail && cmd.last_out;
          if (k_end) begin
            if (cmd.tail) begin
              state_next = BK_VAL;
            end else begin
              cmd_ready  = 1'b1;
              state_next = BK_IDLE;
            end
          end else begin
            k_next  = k + LIT_IW'(1);
            rd_en   = 1'b1;
            rd_addr = k + LIT_IW'(1);
          end
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= BK_IDLE;
      k        <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      k     <= k_next;
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= ld_word;
      m_tuser <= ld_hdr;
      m_tlast <= ld_last;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      lit_mem[cmd.cnt[LIT_IW-1:0]] <= cmd.val;
    end
    if (rd_en) begin
      rd_data <= lit_mem[rd_addr];
    end
  end

  `WRE_ASSERT_NOW(a_lit_cmd, state == BK_LIT, cmd_valid && cmd.op == OP_LITS, "literal state without literal command")
  `WRE_ASSERT_NOW(a_val_cmd, state == BK_VAL, cmd_valid && (cmd.op == OP_PAIR || (cmd.op == OP_LITS && cmd.tail)), "value state without a word to send")

endmodule

### rtl/core/word_rle_encoder_unit.sv
// Word run-length encoder, PackBits style, header signs swapped: 32-bit words
// in, header and data words out. The front classifies each input item into up to
// three commands that pass through a four-entry queue to the back, which sends
// one word per cycle while the output is taken. The front takes a new item every
// cycle while each item yields at most one command and the queue takes it; an
// item with more holds the input off until one is left. The back sends no word
// while it writes a literal into its buffer. The output port is registered, so
// the next item is taken while a word waits. The header byte order is set by a
// single configuration bit (reset value 1 = byte-swapped); the user must write it
// only while the block is idle (not enforced by the block). Depends on wre_pkg.
`timescale 1ns / 1ps

module word_rle_encoder_unit
  import wre_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_wdata,  // swap_header
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [WORD_W-1:0] s_tdata,    // data_word
  input  logic              s_tlast,    // last_word
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [WORD_W-1:0] m_tdata,    // code_word
  output logic              m_tuser,    // is_header
  output logic              m_tlast     // final_of_item
);

  logic swap_header;
  logic f_valid, f_ready;
  cmd_t f_cmd;
  logic b_valid, b_ready;
  cmd_t b_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      swap_header <= 1'b1;
    end else if (cfg_we) begin
      swap_header <= cfg_wdata;
    end
  end

  wre_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  wre_cmd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_cmd   (f_cmd),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_cmd    (b_cmd)
  );

  wre_back u_back (
    .clk         (clk),
    .rst         (rst),
    .swap_header (swap_header),
    .cmd_valid   (b_valid),
    .cmd_ready   (b_ready),
    .cmd         (b_cmd),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast)
  );

endmodule

### dv/tb_word_rle_encoder_unit.sv
// Self-checking testbench for word_rle_encoder_unit: a directed table, then random
// streams of repeat and literal runs, checked word by word against a predictor.
// Depends on wre_pkg and the word_rle_encoder_unit RTL.
`timescale 1ns / 1ps

module tb_word_rle_encoder_unit;
  import wre_pkg::*;

  typedef struct {
    logic [WORD_W-1:0] code;
    logic              hdr;
    logic              fin;
  } code_word_t;

  typedef struct {
    logic [WORD_W-1:0] data;
    logic              last;
    bit                typed;
    logic [WORD_W-1:0] t_hdr;
    logic [WORD_W-1:0] t_val;
  } stim_row_t;

  localparam int                HOLD_CYCLES   = 200;
  localparam int                DRAIN_LIMIT   = 20000;
  localparam int                SETTLE_CYCLES = 100;
  localparam int                PRINT_CAP     = 100;
  localparam logic [WORD_W-1:0] REPEAT_CAP    = {1'b0, {REP_W{1'b1}}};

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic              cfg_wdata = 1'b0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [WORD_W-1:0] s_tdata = '0;
  logic              s_tlast = 1'b0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [WORD_W-1:0] m_tdata;
  logic              m_tuser;
  logic              m_tlast;

  // Predictor state.
  logic [WORD_W-1:0] cur_word;
  logic [WORD_W-1:0] run_tally;
  logic              stream_live;
  logic [WORD_W-1:0] lit_buf [LIT_MAX];
  logic              swap_on;
  code_word_t        expected_codes[$];

  // Description of the item currently offered, for rows with typed results.
  bit                row_typed = 1'b0;
  logic [WORD_W-1:0] row_hdr = '0;
  logic [WORD_W-1:0] row_val = '0;

  logic [WORD_W-1:0] last_sent = '0;
  bit                stream_open = 1'b0;
  bit                calm_in = 1'b0;
  bit                calm_out = 1'b0;
  bit                hold_req = 1'b0;
  int unsigned       ready_wait = 0;

  int mismatches = 0;
  int items_taken = 0;
  int streams_closed = 0;
  int codes_checked = 0;
  int headers_seen = 0;
  int input_stalls = 0;

  stim_row_t opening_rows [21];

  word_rle_encoder_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_CAP) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  function automatic void emit_code(input logic [WORD_W-1:0] w, input logic is_hdr);
    code_word_t c;
    c.code = (is_hdr && swap_on) ? {w[7:0], w[15:8], w[23:16], w[31:24]} : w;
    c.hdr  = is_hdr;
    c.fin  = 1'b0;
    expected_codes.push_back(c);
  endfunction

  // Header holds minus (count - 1), then the buffered words in arrival order.
  function automatic void emit_literals(input int unsigned cnt);
    emit_code(32'd0 - (cnt - 1), 1'b1);
    for (int k = 0; k < cnt; k++) begin
      emit_code(lit_buf[k], 1'b0);
    end
  endfunction

  // run_tally: zero holds only cur_word, positive c is a repeat of c+1 copies,
  // and minus n means n buffered literals ahead of cur_word.
  function automatic void predict_codes(input logic [WORD_W-1:0] d, input logic last);
    int unsigned lits;
    int          first;
    first = expected_codes.size();
    if (!stream_live) begin
      cur_word    = d;
      run_tally   = '0;
      stream_live = 1'b1;
    end else if (run_tally == 0) begin
      if (d == cur_word) begin
        run_tally = 1;
      end else begin
        lit_buf[0] = cur_word;
        cur_word   = d;
        run_tally  = '1;
      end
    end else if (!run_tally[WORD_W-1]) begin
      if (d == cur_word && run_tally < REPEAT_CAP) begin
        run_tally++;
      end else begin
        emit_code(run_tally, 1'b1);
        emit_code(cur_word, 1'b0);
        cur_word  = d;
        run_tally = '0;
      end
    end else begin
      lits = 32'd0 - run_tally;
      if (lits > LIT_MAX) lits = LIT_MAX;
      if (d == cur_word) begin
        emit_literals(lits);
        run_tally = 1;
      end else begin
        if (lits >= LIT_MAX) begin
          emit_literals(lits);
          lits = 0;
        end
        lit_buf[lits] = cur_word;
        cur_word      = d;
        run_tally     = 32'd0 - (lits + 1);
      end
    end

    if (last) begin
      if (!run_tally[WORD_W-1]) begin
        emit_code(run_tally, 1'b1);
        emit_code(cur_word, 1'b0);
      end else begin
        lits = 32'd0 - run_tally;
        if (lits > LIT_MAX) lits = LIT_MAX;
        if (lits >= LIT_MAX) begin
          // A full buffer goes out alone; the pending word becomes a run of one.
          emit_literals(lits);
          emit_code('0, 1'b1);
          emit_code(cur_word, 1'b0);
        end else begin
          lit_buf[lits] = cur_word;
          emit_literals(lits + 1);
        end
      end
      stream_live = 1'b0;
      run_tally   = '0;
    end

    if (expected_codes.size() > first) expected_codes[$].fin = 1'b1;
  endfunction

  always @(posedge clk) begin : monitor
    code_word_t want;
    int         first;
    if (rst) begin
      cur_word    = '0;
      run_tally   = '0;
      stream_live = 1'b0;
      swap_on     = 1'b1;
    end else begin
      if (cfg_we) swap_on = cfg_wdata;
      if (s_tvalid && !s_tready) input_stalls++;

      if (s_tvalid && s_tready) begin
        first = expected_codes.size();
        predict_codes(s_tdata, s_tlast);
        // Typed rows carry their header and value pair straight from the table.
        if (row_typed) begin
          while (expected_codes.size() > first) void'(expected_codes.pop_back());
          expected_codes.push_back(code_word_t'{row_hdr, 1'b1, 1'b0});
          expected_codes.push_back(code_word_t'{row_val, 1'b0, 1'b1});
        end
        items_taken++;
        if (s_tlast) streams_closed++;
      end

      if (m_tvalid && m_tready) begin
        codes_checked++;
        if (m_tuser) headers_seen++;
        if (expected_codes.size() == 0) begin
          report_mismatch($sformatf("unexpected word %h header %b final %b",
                                    m_tdata, m_tuser, m_tlast));
        end else begin
          want = expected_codes.pop_front();
          if (m_tdata !== want.code)
            report_mismatch($sformatf("code word %h, expected %h", m_tdata, want.code));
          if (m_tuser !== want.hdr)
            report_mismatch($sformatf("header flag %b, expected %b on word %h",
                                      m_tuser, want.hdr, want.code));
          if (m_tlast !== want.fin)
            report_mismatch($sformatf("final flag %b, expected %b on word %h",
                                      m_tlast, want.fin, want.code));
        end
        if (hold_req) begin
          ready_wait = HOLD_CYCLES;
          hold_req   = 1'b0;
        end else begin
          if ($urandom_range(0, 15) == 0) calm_out = !calm_out;
          ready_wait = calm_out ? 0 : $urandom_range(0, 5);
        end
      end
    end
  end

  // The receiver counts down its stall, including the long hold, here.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (ready_wait > 0) begin
      m_tready <= 1'b0;
      ready_wait--;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic offer_word(input logic [WORD_W-1:0] d, input logic l, input bit typed,
                            input logic [WORD_W-1:0] th, input logic [WORD_W-1:0] tv);
    int gap;
    if ($urandom_range(0, 15) == 0) calm_in = !calm_in;
    gap = calm_in ? 0 : $urandom_range(0, 5);
    repeat (gap) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid  <= 1'b1;
    s_tdata   <= d;
    s_tlast   <= l;
    row_typed <= typed;
    row_hdr   <= th;
    row_val   <= tv;
    do @(posedge clk); while (!s_tready);
    last_sent   = d;
    stream_open = !l;
  endtask

  task automatic write_swap(input logic v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic drain_codes();
    int waited;
    waited = 0;
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_codes.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    // The settle wait catches any word the block sends beyond the prediction.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_codes.size() != 0) begin
      report_mismatch($sformatf("%0d code words never arrived", expected_codes.size()));
      expected_codes.delete();
    end
  endtask

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return 32'd1 << $urandom_range(0, 31);
      3:       return ~(32'd1 << $urandom_range(0, 31));
      default: return $urandom();
    endcase
  endfunction

  // Streams built from repeat runs, short and long literal runs and some noise.
  // Long literal runs may cross the buffer size; some close right at one word past it.
  task automatic random_phase(input int n_words);
    int               made;
    int               kind;
    int               len;
    logic             l;
    logic [WORD_W-1:0] w;
    made = 0;
    while (made < n_words) begin
      kind = $urandom_range(0, 9);
      if (kind == 8 && stream_open) begin
        offer_word(pick_word(), 1'b1, 1'b0, '0, '0);
        made++;
      end
      case (kind)
        0, 1, 2, 3: len = $urandom_range(1, 6);
        4, 5, 6:    len = $urandom_range(1, 8);
        7:          len = $urandom_range(LIT_MAX - 2, LIT_MAX + 6);
        8:          len = $urandom_range(0, 1) ? LIT_MAX + 1
                                               : $urandom_range(LIT_MAX - 1, LIT_MAX + 2);
        default:    len = 1;
      endcase
      w = pick_word();
      for (int i = 0; i < len; i++) begin
        if (kind >= 4 && kind <= 8) begin
          w = pick_word();
          if (w == last_sent) w = ~w;
        end else if (kind == 9) begin
          case ($urandom_range(0, 2))
            0:       w = last_sent;
            1:       w = '0;
            default: w = $urandom();
          endcase
        end
        if (i != len - 1) l = 1'b0;
        else if (kind == 8) l = 1'b1;
        else if (kind == 9) l = ($urandom_range(0, 2) == 0);
        else l = ($urandom_range(0, 3) == 0);
        offer_word(w, l, 1'b0, '0, '0);
        made++;
      end
    end
    if (stream_open) offer_word(pick_word(), 1'b1, 1'b0, '0, '0);
  endtask

  initial begin
    // A repeat run long enough to overflow the count is out of reach here.
    opening_rows = '{
      '{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, 32'h0000_0000},
      '{32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF},
      '{32'h8000_0000, 1'b0, 1'b0, '0, '0},
      '{32'h8000_0000, 1'b0, 1'b0, '0, '0},
      '{32'h8000_0000, 1'b1, 1'b1, 32'h0200_0000, 32'h8000_0000},
      '{32'h0000_0001, 1'b0, 1'b0, '0, '0},
      '{32'h0000_0002, 1'b0, 1'b0, '0, '0},
      '{32'h0000_0003, 1'b1, 1'b0, '0, '0},
      '{32'h1234_5678, 1'b0, 1'b0, '0, '0},
      '{32'h1234_5678, 1'b0, 1'b0, '0, '0},
      '{32'h9ABC_DEF0, 1'b0, 1'b0, '0, '0},
      '{32'h0F0F_0F0F, 1'b1, 1'b0, '0, '0},
      '{32'hAAAA_AAAA, 1'b0, 1'b0, '0, '0},
      '{32'h5555_5555, 1'b0, 1'b0, '0, '0},
      '{32'h5555_5555, 1'b0, 1'b0, '0, '0},
      '{32'h5555_5555, 1'b1, 1'b0, '0, '0},
      '{32'h1111_1111, 1'b0, 1'b0, '0, '0},
      '{32'h1111_1111, 1'b0, 1'b0, '0, '0},
      '{32'h2222_2222, 1'b0, 1'b0, '0, '0},
      '{32'h3333_3333, 1'b0, 1'b0, '0, '0},
      '{32'h3333_3333, 1'b1, 1'b0, '0, '0}
    };

    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // Byte-swapped headers: directed rows, then random streams.
    write_swap(1'b1);
    foreach (opening_rows[i]) begin
      offer_word(opening_rows[i].data, opening_rows[i].last, opening_rows[i].typed,
                 opening_rows[i].t_hdr, opening_rows[i].t_val);
    end
    random_phase(100);
    drain_codes();

    // Native header order, with one long output stall in the middle.
    write_swap(1'b0);
    random_phase(55);
    hold_req = 1'b1;
    random_phase(50);
    drain_codes();

    write_swap(1'b1);
    random_phase(100);
    drain_codes();

    $display("Run covered %0d items in %0d streams and %0d code words (%0d headers),",
             items_taken, streams_closed, codes_checked, headers_seen);
    $display("both header orders, and %0d cycles with the input held off by the block.",
             input_stalls);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/wre_pkg.sv
rtl/core/wre_front.sv
rtl/core/wre_cmd_fifo.sv
rtl/core/wre_back.sv
rtl/core/word_rle_encoder_unit.sv
dv/tb_word_rle_encoder_unit.sv
